// ===== rtl/core/sgrav_pkg.sv =====
// Shared types, register codes and constants of the softened two-body gravity block.
package sgrav_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FIELD_W         = 32;
   localparam int CFG_W           = 32;
   localparam int ADDR_W          = 5;
   localparam int ACC_Q_W         = 34;
   localparam int ACC_SHIFT       = 40;
   localparam int POT_SHIFT       = 16;
   localparam int POT_Q_W         = CFG_W + POT_SHIFT;

   // acceleration term magnitude cap, 2^33
   localparam logic [ACC_Q_W-1:0] ACC_CAP = ACC_Q_W'(1) << (ACC_Q_W - 1);

   localparam logic [CFG_W-1:0] MASS_ONE_RST   = 32'h0100_0000;
   localparam logic [CFG_W-1:0] MASS_TWO_RST   = 32'h0019_999A;
   localparam logic [CFG_W-1:0] BODY_ONE_X_RST = 32'hFFE6_6666;
   localparam logic [CFG_W-1:0] BODY_TWO_X_RST = 32'h0100_0000;
   localparam logic [CFG_W-1:0] SOFT_SQ_RST    = 32'h0000_0000;

   typedef enum logic [2:0] {
      REG_MASS_ONE,
      REG_MASS_TWO,
      REG_BODY_ONE_X,
      REG_BODY_TWO_X,
      REG_SOFT_SQ
   } reg_idx_type;

   typedef struct packed {
      logic [CFG_W-1:0] mass_one;
      logic [CFG_W-1:0] mass_two;
      logic [CFG_W-1:0] body_one_x;
      logic [CFG_W-1:0] body_two_x;
      logic [CFG_W-1:0] soft_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] potential;
      logic signed [FIELD_W-1:0] acc_x;
      logic signed [FIELD_W-1:0] acc_y;
      logic signed [FIELD_W-1:0] acc_z;
      logic                      overflow_flag;
   } rsp_type;

endpackage

// ===== rtl/core/softened_two_body_gravity.sv =====
// Top level: softened two-body gravity pipeline with register port.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  sgrav_pkg::req_type (pos_x, pos_y, pos_z)
//   rsp      out        rsp_valid/rsp_stall  sgrav_pkg::rsp_type (potential, acc, flag)
//   csr      in/out     APB psel/penable     five 32-bit registers at 4*i
//
// One position enters per cycle while req_stall is low; the depth of the pipe is set
// mainly by the one-bit-per-stage square root and the 48-step potential divider.
// Reset clears the valid pipe and loads the register defaults.
// While a finished result is stalled the whole pipe holds and req_stall is high.
module softened_two_body_gravity #(
   parameter int COORD_WIDTH = sgrav_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sgrav_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sgrav_pkg::rsp_type             rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sgrav_pkg::ADDR_W-1:0]   paddr,
   input  logic [sgrav_pkg::CFG_W-1:0]    pwdata,
   output logic [sgrav_pkg::CFG_W-1:0]    prdata,
   output logic                           pready
);

   localparam int CB     = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int D_W    = CB + 1;
   localparam int MAG_W  = CB + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int CFG_W  = sgrav_pkg::CFG_W;
   localparam int R_W0   = ((2 * CB > CFG_W + 24) ? 2 * CB : CFG_W + 24) + 2;
   localparam int R_W    = R_W0 + (R_W0 % 2);
   localparam int S_W    = R_W / 2;
   localparam int RL_W   = R_W / 2;
   localparam int RH_W   = R_W - RL_W;
   localparam int SL_W   = S_W / 2;
   localparam int SH_W   = S_W - SL_W;
   localparam int PP_W   = RH_W + SH_W;
   localparam int DEN_W  = R_W + S_W;
   localparam int NM_W   = CFG_W + MAG_W;
   localparam int NUM_W  = NM_W + sgrav_pkg::ACC_SHIFT;
   localparam int AQ_W   = sgrav_pkg::ACC_Q_W;
   localparam int PQ_W   = sgrav_pkg::POT_Q_W;
   localparam int ASUM_W = AQ_W + 2;
   localparam int LAT    = 3 + S_W + 2 + PQ_W + 1 + 1;

   typedef struct packed {
      logic [R_W-1:0]              r1;
      logic [R_W-1:0]              r2;
      logic [3:0][MAG_W-1:0]       mag;
      logic [3:0]                  neg;
      logic [1:0]                  sing;
   } aux1_type;

   typedef struct packed {
      logic [3:0] neg;
      logic [1:0] sing;
   } aux2_type;

   // ---------------- configuration registers ----------------
   sgrav_pkg::cfg_type      cfg_ff;
   sgrav_pkg::reg_idx_type  csr_idx;

   assign csr_idx = sgrav_pkg::reg_idx_type'(paddr[sgrav_pkg::ADDR_W-1:2]);
   assign pready  = 1'b1;

   // write a register on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mass_one   <= sgrav_pkg::MASS_ONE_RST;
         cfg_ff.mass_two   <= sgrav_pkg::MASS_TWO_RST;
         cfg_ff.body_one_x <= sgrav_pkg::BODY_ONE_X_RST;
         cfg_ff.body_two_x <= sgrav_pkg::BODY_TWO_X_RST;
         cfg_ff.soft_sq    <= sgrav_pkg::SOFT_SQ_RST;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx)
            sgrav_pkg::REG_MASS_ONE:   cfg_ff.mass_one   <= pwdata;
            sgrav_pkg::REG_MASS_TWO:   cfg_ff.mass_two   <= pwdata;
            sgrav_pkg::REG_BODY_ONE_X: cfg_ff.body_one_x <= pwdata;
            sgrav_pkg::REG_BODY_TWO_X: cfg_ff.body_two_x <= pwdata;
            sgrav_pkg::REG_SOFT_SQ:    cfg_ff.soft_sq    <= pwdata;
            default: ;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      unique case (csr_idx)
         sgrav_pkg::REG_MASS_ONE:   prdata = cfg_ff.mass_one;
         sgrav_pkg::REG_MASS_TWO:   prdata = cfg_ff.mass_two;
         sgrav_pkg::REG_BODY_ONE_X: prdata = cfg_ff.body_one_x;
         sgrav_pkg::REG_BODY_TWO_X: prdata = cfg_ff.body_two_x;
         sgrav_pkg::REG_SOFT_SQ:    prdata = cfg_ff.soft_sq;
         default:                   prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic           advance;
   logic [LAT-1:0] vld_ff;

   assign advance   = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[LAT-1];

   // shift valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- stage 1: offsets ----------------
   logic [CB-1:0]  px, py, pz, bx1, bx2;
   logic [D_W-1:0] d_ff [4];

   assign px  = req_data.pos_x[CB-1:0];
   assign py  = req_data.pos_y[CB-1:0];
   assign pz  = req_data.pos_z[CB-1:0];
   assign bx1 = cfg_ff.body_one_x[CB-1:0];
   assign bx2 = cfg_ff.body_two_x[CB-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0] <= {px[CB-1], px} - {bx1[CB-1], bx1};
         d_ff[1] <= {px[CB-1], px} - {bx2[CB-1], bx2};
         d_ff[2] <= {py[CB-1], py};
         d_ff[3] <= {pz[CB-1], pz};
      end
   end

   // ---------------- stage 2: magnitudes and squares ----------------
   logic [MAG_W-1:0] mag_in [4];
   logic [MAG_W-1:0] mag2_ff [4];
   logic [3:0]       neg2_ff;
   logic [SQ_W-1:0]  sq_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mag_in[k] = d_ff[k][D_W-1] ? MAG_W'(~d_ff[k] + D_W'(1)) : MAG_W'(d_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            mag2_ff[k] <= mag_in[k];
            neg2_ff[k] <= d_ff[k][D_W-1];
            sq_ff[k]   <= SQ_W'(mag_in[k]) * SQ_W'(mag_in[k]);
         end
      end
   end

   // ---------------- stage 3: squared softened distances ----------------
   aux1_type aux3_ff;
   aux1_type aux3_cur;
   logic [R_W-1:0] soft_r;

   assign soft_r = R_W'(cfg_ff.soft_sq) << 24;

   always_ff @(posedge clock) begin
      if (advance) begin
         aux3_ff.r1  <= R_W'(sq_ff[0]) + R_W'(sq_ff[2]) + R_W'(sq_ff[3]) + soft_r;
         aux3_ff.r2  <= R_W'(sq_ff[1]) + R_W'(sq_ff[2]) + R_W'(sq_ff[3]) + soft_r;
         for (int k = 0; k < 4; k++) begin
            aux3_ff.mag[k] <= mag2_ff[k];
         end
         aux3_ff.neg  <= neg2_ff;
         aux3_ff.sing <= '0;
      end
   end

   // flag a zero distance before the root
   always_comb begin
      aux3_cur         = aux3_ff;
      aux3_cur.sing[0] = aux3_ff.r1 == '0;
      aux3_cur.sing[1] = aux3_ff.r2 == '0;
   end

   // ---------------- square roots ----------------
   logic [S_W-1:0] root [2];
   aux1_type       aux_sq;

   sgrav_isqrt #(.IN_W(R_W)) u_isqrt_one (
      .clock (clock), .en (advance), .rad (aux3_ff.r1), .root (root[0])
   );

   sgrav_isqrt #(.IN_W(R_W)) u_isqrt_two (
      .clock (clock), .en (advance), .rad (aux3_ff.r2), .root (root[1])
   );

   sgrav_delay #(.W($bits(aux1_type)), .D(S_W)) u_dly_root (
      .clock (clock), .en (advance), .din (aux3_cur), .dout (aux_sq)
   );

   // ---------------- stage A: partial products ----------------
   logic [PP_W-1:0] pp_ff [2][4];
   logic [NM_W-1:0] nm_ff [6];
   logic [S_W-1:0]  sa_ff [2];
   aux2_type        auxa_ff;
   logic [R_W-1:0]  rr [2];
   logic [CFG_W-1:0] mass [2];

   assign rr[0]   = aux_sq.r1;
   assign rr[1]   = aux_sq.r2;
   assign mass[0] = cfg_ff.mass_one;
   assign mass[1] = cfg_ff.mass_two;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int b = 0; b < 2; b++) begin
            pp_ff[b][0] <= PP_W'(rr[b][RL_W-1:0]) * PP_W'(root[b][SL_W-1:0]);
            pp_ff[b][1] <= PP_W'(rr[b][RL_W-1:0]) * PP_W'(root[b][S_W-1:SL_W]);
            pp_ff[b][2] <= PP_W'(rr[b][R_W-1:RL_W]) * PP_W'(root[b][SL_W-1:0]);
            pp_ff[b][3] <= PP_W'(rr[b][R_W-1:RL_W]) * PP_W'(root[b][S_W-1:SL_W]);
            sa_ff[b]    <= root[b];
            nm_ff[3*b]   <= NM_W'(mass[b]) * NM_W'(aux_sq.mag[b]);
            nm_ff[3*b+1] <= NM_W'(mass[b]) * NM_W'(aux_sq.mag[2]);
            nm_ff[3*b+2] <= NM_W'(mass[b]) * NM_W'(aux_sq.mag[3]);
         end
         auxa_ff.neg  <= aux_sq.neg;
         auxa_ff.sing <= aux_sq.sing;
      end
   end

   // ---------------- stage B: denominators ----------------
   logic [DEN_W-1:0] den_ff [2];
   logic [NUM_W-1:0] numa_ff [6];
   logic [S_W-1:0]   sb_ff [2];
   aux2_type         auxb_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int b = 0; b < 2; b++) begin
            den_ff[b] <= DEN_W'(pp_ff[b][0])
                       + (DEN_W'(pp_ff[b][1]) << SL_W)
                       + (DEN_W'(pp_ff[b][2]) << RL_W)
                       + (DEN_W'(pp_ff[b][3]) << (RL_W + SL_W));
            sb_ff[b]  <= sa_ff[b];
         end
         for (int j = 0; j < 6; j++) begin
            numa_ff[j] <= {nm_ff[j], sgrav_pkg::ACC_SHIFT'(0)};
         end
         auxb_ff <= auxa_ff;
      end
   end

   // ---------------- dividers ----------------
   logic [AQ_W-1:0]   acc_q   [6];
   logic              acc_ovf [6];
   logic [6*AQ_W-1:0] acc_cap;
   logic [6*AQ_W-1:0] acc_dly;
   logic [PQ_W-1:0]   pot_q   [2];
   logic              pot_ovf [2];
   aux2_type          aux_end;

   for (genvar j = 0; j < 6; j++) begin : g_acc_div
      sgrav_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(AQ_W)) u_div (
         .clock (clock), .en (advance), .num (numa_ff[j]), .den (den_ff[j/3]),
         .quo (acc_q[j]), .ovf (acc_ovf[j])
      );
      // cap the term magnitude
      assign acc_cap[j*AQ_W +: AQ_W] = (acc_ovf[j] || acc_q[j] > sgrav_pkg::ACC_CAP)
                                     ? sgrav_pkg::ACC_CAP : acc_q[j];
   end

   for (genvar b = 0; b < 2; b++) begin : g_pot_div
      sgrav_div #(.NUM_W(PQ_W), .DEN_W(S_W), .Q_W(PQ_W)) u_div (
         .clock (clock), .en (advance),
         .num ({mass[b], sgrav_pkg::POT_SHIFT'(0)}), .den (sb_ff[b]),
         .quo (pot_q[b]), .ovf (pot_ovf[b])
      );
   end

   sgrav_delay #(.W(6*AQ_W), .D(PQ_W - AQ_W)) u_dly_acc (
      .clock (clock), .en (advance), .din (acc_cap), .dout (acc_dly)
   );

   sgrav_delay #(.W($bits(aux2_type)), .D(PQ_W + 1)) u_dly_side (
      .clock (clock), .en (advance), .din (auxb_ff), .dout (aux_end)
   );

   // ---------------- final stage: sum and saturate ----------------
   function automatic logic [ASUM_W-1:0] acc_term(input logic [AQ_W-1:0] a,
                                                  input logic neg, input logic sing);
      logic [ASUM_W-1:0] ext;
      ext = ASUM_W'(a);
      if (sing) begin
         return '0;
      end else if (neg) begin
         return ext;
      end else begin
         return ~ext + ASUM_W'(1);
      end
   endfunction

   function automatic logic [32:0] sat32(input logic [ASUM_W-1:0] v);
      logic [ASUM_W-32:0] top;
      top = v[ASUM_W-1:31];
      if ((&top) || !(|top)) begin
         return {1'b0, v[31:0]};
      end else if (v[ASUM_W-1]) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b1, 32'h7FFF_FFFF};
      end
   endfunction

   logic [PQ_W-1:0]   pm [2];
   logic [PQ_W:0]     psum;
   logic [PQ_W:0]     pneg;
   logic              pot_sat;
   logic [32:0]       ax, ay, az;
   logic [AQ_W-1:0]   a_t [6];
   sgrav_pkg::rsp_type rsp_in;
   sgrav_pkg::rsp_type rsp_ff;

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         a_t[j] = acc_dly[j*AQ_W +: AQ_W];
      end
      for (int b = 0; b < 2; b++) begin
         pm[b] = aux_end.sing[b] ? PQ_W'(sgrav_pkg::ACC_CAP) : pot_q[b];
      end
      psum    = {1'b0, pm[0]} + {1'b0, pm[1]};
      pneg    = ~psum + (PQ_W+1)'(1);
      pot_sat = psum > ((PQ_W+1)'(1) << 31);
      ax = sat32(acc_term(a_t[0], aux_end.neg[0], aux_end.sing[0])
               + acc_term(a_t[3], aux_end.neg[1], aux_end.sing[1]));
      ay = sat32(acc_term(a_t[1], aux_end.neg[2], aux_end.sing[0])
               + acc_term(a_t[4], aux_end.neg[2], aux_end.sing[1]));
      az = sat32(acc_term(a_t[2], aux_end.neg[3], aux_end.sing[0])
               + acc_term(a_t[5], aux_end.neg[3], aux_end.sing[1]));
      rsp_in.potential     = pot_sat ? 32'h8000_0000 : pneg[31:0];
      rsp_in.acc_x         = ax[31:0];
      rsp_in.acc_y         = ay[31:0];
      rsp_in.acc_z         = az[31:0];
      rsp_in.overflow_flag = pot_sat || ax[32] || ay[32] || az[32] || (|aux_end.sing);
   end

   // hold the result register while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   // an accepted transfer enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transfer missing from first stage");

   // a stalled result freezes the whole valid pipe
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipeline moved under a stalled result");

   // potential is never positive unless the flag is raised
   a_pot_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.overflow_flag)
      |-> (rsp_data.potential[31] || rsp_data.potential == '0))
      else $error("positive potential without flag");
`endif

endmodule

// ===== rtl/core/sgrav_delay.sv =====
// Enabled shift-register delay line for side data that travels with the pipeline.
module sgrav_delay #(
   parameter int W = 8,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] dly_ff [D];

   // advance the line on enable
   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= din;
         for (int k = 1; k < D; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign dout = dly_ff[D-1];

endmodule

// ===== rtl/core/sgrav_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module sgrav_isqrt #(
   parameter int IN_W = 66
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   rad,
   output logic [IN_W/2-1:0] root
);

   localparam int S_W   = IN_W / 2;
   localparam int REM_W = S_W + 2;

   logic [IN_W-1:0]  val_ff  [S_W];
   logic [REM_W-1:0] rem_ff  [S_W];
   logic [S_W-1:0]   root_ff [S_W];
   logic [IN_W-1:0]  val_in  [S_W];
   logic [REM_W-1:0] rem_in  [S_W];
   logic [S_W-1:0]   root_in [S_W];

   // one digit step per stage: bring down two radicand bits, try 4*root+1
   always_comb begin
      logic [IN_W-1:0]    v_src;
      logic [REM_W-1:0]   r_src;
      logic [S_W-1:0]     q_src;
      logic [REM_W+1:0]   rem_n;
      logic [REM_W+1:0]   trial;
      logic               ge;
      for (int k = 0; k < S_W; k++) begin
         if (k == 0) begin
            v_src = rad;
            r_src = '0;
            q_src = '0;
         end else begin
            v_src = val_ff[k-1];
            r_src = rem_ff[k-1];
            q_src = root_ff[k-1];
         end
         rem_n = {r_src, v_src[IN_W-1 -: 2]};
         trial = (REM_W+2)'({q_src, 2'b01});
         ge    = rem_n >= trial;
         val_in[k]  = v_src << 2;
         rem_in[k]  = ge ? REM_W'(rem_n - trial) : REM_W'(rem_n);
         root_in[k] = {q_src[S_W-2:0], ge};
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= val_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[S_W-1];

endmodule

// ===== rtl/core/sgrav_div.sv =====
// Pipelined restoring divider with quotient overflow detect, one quotient bit per stage.
module sgrav_div #(
   parameter int NUM_W = 105,
   parameter int DEN_W = 99,
   parameter int Q_W   = 34
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo,
   output logic             ovf
);

   localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

   logic [NUM_W-1:0] rem_ff [Q_W+1];
   logic [DEN_W-1:0] den_ff [Q_W+1];
   logic [Q_W-1:0]   q_ff   [Q_W+1];
   logic             ovf_ff [Q_W+1];
   logic [NUM_W-1:0] rem_in [Q_W+1];
   logic [DEN_W-1:0] den_in [Q_W+1];
   logic [Q_W-1:0]   q_in   [Q_W+1];
   logic             ovf_in [Q_W+1];

   // load stage flags a quotient wider than Q_W bits, then one subtract per stage
   always_comb begin
      logic [W-1:0] dsh;
      logic         ge;
      rem_in[0] = num;
      den_in[0] = den;
      q_in[0]   = '0;
      ovf_in[0] = W'(num) >= (W'(den) << Q_W);
      for (int k = 1; k <= Q_W; k++) begin
         dsh       = W'(den_ff[k-1]) << (Q_W - k);
         ge        = W'(rem_ff[k-1]) >= dsh;
         rem_in[k] = ge ? NUM_W'(W'(rem_ff[k-1]) - dsh) : rem_ff[k-1];
         den_in[k] = den_ff[k-1];
         q_in[k]   = {q_ff[k-1][Q_W-2:0], ge};
         ovf_in[k] = ovf_ff[k-1];
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         q_ff   <= q_in;
         ovf_ff <= ovf_in;
      end
   end

   assign quo = q_ff[Q_W];
   assign ovf = ovf_ff[Q_W];

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the softened two-body gravity pipeline.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 88;
   localparam int SETTLE    = LATENCY + 20;
   localparam int LIMIT     = 400000;
   localparam int MAX_SHOWN = 10;
   localparam logic [63:0] TERM_CAP = 64'd1 << 33;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sgrav_pkg::req_type   req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sgrav_pkg::rsp_type   rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [sgrav_pkg::ADDR_W-1:0] paddr = '0;
   logic [sgrav_pkg::CFG_W-1:0]  pwdata = '0;
   logic [sgrav_pkg::CFG_W-1:0]  prdata;
   logic                 pready;

   // testbench copy of the register file
   logic [31:0]        m_one, m_two, soft_len_sq;
   logic signed [31:0] bx_one, bx_two;

   sgrav_pkg::rsp_type expected_fields[$];
   int      mismatches = 0;
   int      checked = 0;
   int      sent = 0;
   int      cfg_writes = 0;
   int      cycles = 0;
   int      long_hold = 0;
   bit      idle_en = 1'b0;
   int      stall_burst = 0;

   softened_two_body_gravity uut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One body's potential magnitude and acceleration terms.
   function automatic void body_contrib(input logic signed [33:0] dx, dy, dz,
                                        input logic [31:0] m,
                                        output logic [63:0] pot_mag,
                                        output logic signed [63:0] ax, ay, az,
                                        inout bit sing);
      logic signed [33:0] d[3];
      logic [33:0]        mg[3];
      logic signed [63:0] a_out[3];
      logic [127:0]       r, den, num, q;
      logic [63:0]        s, c, a;
      d[0] = dx; d[1] = dy; d[2] = dz;
      r = 128'(soft_len_sq) << 24;
      for (int i = 0; i < 3; i++) begin
         mg[i] = d[i] < 0 ? 34'(-d[i]) : 34'(d[i]);
         r += 128'(mg[i]) * 128'(mg[i]);
      end
      if (r == 0) begin
         sing = 1'b1;
         pot_mag = TERM_CAP;
         ax = 0; ay = 0; az = 0;
         return;
      end
      s = 0;
      for (int i = 63; i >= 0; i--) begin
         c = s | (64'd1 << i);
         if (128'(c) * 128'(c) <= r) s = c;
      end
      pot_mag = (64'(m) << 16) / s;
      den = r * 128'(s);
      for (int i = 0; i < 3; i++) begin
         num = (128'(m) * 128'(mg[i])) << 40;
         q = num / den;
         a = (q > 128'(TERM_CAP)) ? TERM_CAP : q[63:0];
         a_out[i] = d[i] > 0 ? -$signed(a) : $signed(a);
      end
      ax = a_out[0]; ay = a_out[1]; az = a_out[2];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v, inout bit f);
      if (v > 64'sd2147483647) begin
         f = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         f = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic sgrav_pkg::rsp_type gravity_predict(input sgrav_pkg::req_type p);
      logic signed [33:0] d1x, d2x, py, pz;
      logic [63:0]        pm1, pm2;
      logic signed [63:0] a1x, a1y, a1z, a2x, a2y, a2z;
      bit                 f;
      sgrav_pkg::rsp_type r;
      f = 1'b0;
      d1x = $signed(p.pos_x) - bx_one;
      d2x = $signed(p.pos_x) - bx_two;
      py  = $signed(p.pos_y);
      pz  = $signed(p.pos_z);
      body_contrib(d1x, py, pz, m_one, pm1, a1x, a1y, a1z, f);
      body_contrib(d2x, py, pz, m_two, pm2, a2x, a2y, a2z, f);
      r.potential = sat32(-$signed(pm1 + pm2), f);
      r.acc_x = sat32(a1x + a2x, f);
      r.acc_y = sat32(a1y + a2y, f);
      r.acc_z = sat32(a1z + a2z, f);
      r.overflow_flag = f;
      return r;
   endfunction

   // Offer one position; hold it until the transfer, then queue its result.
   task automatic send_pos(input sgrav_pkg::req_type p);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      expected_fields.push_back(gravity_predict(p));
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write: setup then access phase; the register updates on the access edge.
   task automatic csr_write(input sgrav_pkg::reg_idx_type idx, input logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= sgrav_pkg::ADDR_W'(4 * int'(idx)); pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         sgrav_pkg::REG_MASS_ONE:   m_one = v;
         sgrav_pkg::REG_MASS_TWO:   m_two = v;
         sgrav_pkg::REG_BODY_ONE_X: bx_one = v;
         sgrav_pkg::REG_BODY_TWO_X: bx_two = v;
         sgrav_pkg::REG_SOFT_SQ:    soft_len_sq = v;
         default: ;
      endcase
      cfg_writes++;
   endtask

   task automatic set_config(input logic [31:0] m1, m2, b1, b2, s);
      csr_write(sgrav_pkg::REG_MASS_ONE, m1);
      csr_write(sgrav_pkg::REG_MASS_TWO, m2);
      csr_write(sgrav_pkg::REG_BODY_ONE_X, b1);
      csr_write(sgrav_pkg::REG_BODY_TWO_X, b2);
      csr_write(sgrav_pkg::REG_SOFT_SQ, s);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return bx_one + $signed(32'($urandom_range(0, 65535)) - 32'd32768);
         2: return bx_two + $signed(32'($urandom_range(0, 16777215)) - 32'd8388608);
         3: return 32'($signed($urandom_range(0, 2 ** 28)) - 2 ** 27);
         4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
      endcase
   endfunction

   function automatic sgrav_pkg::req_type rand_pos();
      sgrav_pkg::req_type p;
      p.pos_x = rand_coord();
      p.pos_y = rand_coord();
      p.pos_z = rand_coord();
      // land on a body now and then
      if ($urandom_range(0, 15) == 0) begin
         p.pos_x = $urandom_range(0, 1) ? bx_one : bx_two;
         p.pos_y = '0;
         p.pos_z = '0;
      end
      return p;
   endfunction

   function automatic logic [31:0] rand_cfg_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 2 ** 26);
         2: return 32'd0;
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
      endcase
   endfunction

   // Check each result transfer against the oldest prediction.
   always @(posedge clock) begin
      sgrav_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected result %h", rsp_data);
         end else begin
            e = expected_fields.pop_front();
            checked++;
            if (rsp_data.potential !== e.potential || rsp_data.acc_x !== e.acc_x ||
                rsp_data.acc_y !== e.acc_y || rsp_data.acc_z !== e.acc_z ||
                rsp_data.overflow_flag !== e.overflow_flag) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch pot %h/%h ax %h/%h ay %h/%h az %h/%h flag %b/%b",
                           e.potential, rsp_data.potential, e.acc_x, rsp_data.acc_x,
                           e.acc_y, rsp_data.acc_y, e.acc_z, rsp_data.acc_z,
                           e.overflow_flag, rsp_data.overflow_flag);
            end
         end
      end
   end

   // Drive receiver stalls: long hold first, then random bursts.
   always @(posedge clock) begin
      if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         stall_burst <= $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_directed();
      sgrav_pkg::req_type p;
      logic [31:0] edges[5];
      edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
      // on body one with no softening, then on body two
      p = '{bx_one, 32'sd0, 32'sd0};
      send_pos(p);
      p = '{bx_two, 32'sd0, 32'sd0};
      send_pos(p);
      for (int i = 0; i < 5; i++) begin
         p = '{edges[i], edges[(i + 1) % 5], edges[(i + 3) % 5]};
         send_pos(p);
         p = '{edges[i], edges[i], edges[i]};
         send_pos(p);
      end
      drain();
   endtask

   task automatic test_config_extremes();
      sgrav_pkg::req_type p;
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 8; i++) send_pos(rand_pos());
      drain();
      set_config(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) send_pos(rand_pos());
      drain();
      // softening makes the on-body point regular
      set_config(sgrav_pkg::MASS_ONE_RST, sgrav_pkg::MASS_TWO_RST,
                 sgrav_pkg::BODY_ONE_X_RST, sgrav_pkg::BODY_TWO_X_RST, 32'h0001_0000);
      p = '{bx_one, 32'sd0, 32'sd0};
      send_pos(p);
      drain();
   endtask

   task automatic test_random(input int n, input int per_cfg);
      for (int i = 0; i < n; i++) begin
         if (i % per_cfg == per_cfg - 1) begin
            drain();
            set_config(rand_cfg_word(), rand_cfg_word(), rand_cfg_word(),
                       rand_cfg_word(), $urandom_range(0, 1) ? 32'h0 : rand_cfg_word());
         end
         send_pos(rand_pos());
      end
   endtask

   task automatic test_backpressure();
      long_hold = 300;
      idle_en = 1'b0;
      for (int i = 0; i < 150; i++) send_pos(rand_pos());
      drain();
   endtask

   initial begin
      m_one = sgrav_pkg::MASS_ONE_RST; m_two = sgrav_pkg::MASS_TWO_RST;
      bx_one = sgrav_pkg::BODY_ONE_X_RST; bx_two = sgrav_pkg::BODY_TWO_X_RST;
      soft_len_sq = sgrav_pkg::SOFT_SQ_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_en = 1'b1;
      test_config_extremes();
      test_random(500, 100);
      test_backpressure();
      idle_en = 1'b0;
      test_random(100, 1000);
      drain();
      $display("run: %0d positions checked against %0d predictions, %0d register writes,",
               checked, sent, cfg_writes);
      $display("     covering singular points, saturating fields and a long output hold");
      if (mismatches == 0 && expected_fields.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
